/* hw/rtl/ubdc_pkg.sv */
// shared types and constants of the uart baud divisor calculator
package ubdc_pkg;

    localparam int CLK_W      = 26;
    localparam int BAUD_W     = 22;
    localparam int FRAC_W     = 4;
    localparam int NUM_W      = CLK_W + FRAC_W;
    localparam int PRESCALE_W = 16;
    localparam int MOD_W      = 8;

    // oversampling threshold on the integer quotient clock / baud
    localparam logic [NUM_W-FRAC_W-1:0] OVERSAMPLE_MIN = (NUM_W-FRAC_W)'(48);

    // one division step's working set, handed from cell to cell
    typedef struct packed {
        logic [BAUD_W-1:0] baud;
        logic [BAUD_W-1:0] rem;
        logic [NUM_W-1:0]  num;
        logic [NUM_W-1:0]  quot;
    } work_t;

endpackage

/* hw/rtl/ubdc_if.sv */
// request and result channel interfaces
interface ubdc_req_if;
    logic                           valid;
    logic                           ready;
    logic [ubdc_pkg::CLK_W-1:0]     clock_hz;
    logic [ubdc_pkg::BAUD_W-1:0]    baud_rate;

    modport source (output valid, output clock_hz, output baud_rate, input ready);
    modport sink (input valid, input clock_hz, input baud_rate, output ready);
endinterface

interface ubdc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              oversample;
    logic [ubdc_pkg::PRESCALE_W-1:0]   prescaler;
    logic [ubdc_pkg::MOD_W-1:0]        modulation;
    logic                              prescaler_overflow;
    logic                              divide_error;

    modport source (output valid, output oversample, output prescaler, output modulation,
                    output prescaler_overflow, output divide_error, input ready);
    modport sink (input valid, input oversample, input prescaler, input modulation,
                  input prescaler_overflow, input divide_error, output ready);
endinterface

/* hw/rtl/uart_baud_divisor_calc.sv */
// uart baud divisor calculator: pipelined divider chain and result stage
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------------
//   req     | in  | clock_hz[25:0], baud_rate[21:0]
//   rsp     | out | oversample, prescaler[15:0], modulation[7:0],
//           |     | prescaler_overflow, divide_error
//
// one beat per cycle while the result is not stalled; 30 division cells, one quotient
// bit each, then the result register
// the whole chain advances together whenever the result register is empty or taken
// a stalled result holds every cell, so req.ready drops with rsp.ready
// reset clears the valid bits only
module uart_baud_divisor_calc
(
    input  logic          clk,
    input  logic          rst_n,
    ubdc_req_if.sink      req,
    ubdc_rsp_if.source    rsp
);

    localparam int NW = ubdc_pkg::NUM_W;
    localparam int FW = ubdc_pkg::FRAC_W;

    logic            en;
    logic            cell_valid [NW+1];
    ubdc_pkg::work_t cell_work  [NW+1];

    // chain moves when the output slot is free
    assign en        = ~rsp.valid | rsp.ready;
    assign req.ready = en;

    // load the first cell with the scaled clock
    always_comb
    begin
        cell_valid[0]     = req.valid;
        cell_work[0].baud = req.baud_rate;
        cell_work[0].rem  = '0;
        cell_work[0].num  = {req.clock_hz, {FW{1'b0}}};
        cell_work[0].quot = '0;
    end

    // one cell per quotient bit
    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        ubdc_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cell_valid[i]),
            .in_work   (cell_work[i]),
            .out_valid (cell_valid[i+1]),
            .out_work  (cell_work[i+1])
        );
    end

    // result stage
    ubdc_finish u_finish
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .en                 (en),
        .in_valid           (cell_valid[NW]),
        .in_work            (cell_work[NW]),
        .out_valid          (rsp.valid),
        .oversample         (rsp.oversample),
        .prescaler          (rsp.prescaler),
        .modulation         (rsp.modulation),
        .prescaler_overflow (rsp.prescaler_overflow),
        .divide_error       (rsp.divide_error)
    );

endmodule

/* hw/rtl/ubdc_cell.sv */
// one restoring division step with its pipeline register
module ubdc_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  ubdc_pkg::work_t in_work,
    output logic            out_valid,
    output ubdc_pkg::work_t out_work
);

    localparam int BW = ubdc_pkg::BAUD_W;
    localparam int NW = ubdc_pkg::NUM_W;

    logic            valid_reg;
    ubdc_pkg::work_t work_reg;
    ubdc_pkg::work_t work_next;
    logic [BW:0]     shifted;
    logic [BW+1:0]   diff;
    logic            take;

    // shift in next dividend bit and try to subtract the divisor
    always_comb
    begin
        shifted = {in_work.rem, in_work.num[NW-1]};
        diff    = {1'b0, shifted} - {2'b00, in_work.baud};
        take    = ~diff[BW+1];

        work_next      = in_work;
        work_next.rem  = take ? diff[BW-1:0] : shifted[BW-1:0];
        work_next.num  = {in_work.num[NW-2:0], 1'b0};
        work_next.quot = {in_work.quot[NW-2:0], take};
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // working set
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

/* hw/rtl/ubdc_finish.sv */
// mode choice, modulation rounding and output register
module ubdc_finish
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  ubdc_pkg::work_t                   in_work,
    output logic                              out_valid,
    output logic                              oversample,
    output logic [ubdc_pkg::PRESCALE_W-1:0]   prescaler,
    output logic [ubdc_pkg::MOD_W-1:0]        modulation,
    output logic                              prescaler_overflow,
    output logic                              divide_error
);

    localparam int NW = ubdc_pkg::NUM_W;
    localparam int FW = ubdc_pkg::FRAC_W;
    localparam int PW = ubdc_pkg::PRESCALE_W;
    localparam int MW = ubdc_pkg::MOD_W;
    localparam int DW = NW - FW;

    logic          valid_reg;
    logic          os_reg;
    logic [PW-1:0] pre_reg;
    logic [MW-1:0] mod_reg;
    logic          ovf_reg;
    logic          err_reg;

    logic          os_next;
    logic [PW-1:0] pre_next;
    logic [MW-1:0] mod_next;
    logic          ovf_next;
    logic          err_next;
    logic [DW-1:0] div;
    logic [3:0]    plain_sum;
    logic [4:0]    os_sum;
    logic [NW-1:0] q;

    // pick mode, round modulation, dropping the carry
    always_comb
    begin
        q         = in_work.quot;
        err_next  = (in_work.baud == '0);
        os_next   = (q[NW-1:FW] >= ubdc_pkg::OVERSAMPLE_MIN);
        plain_sum = q[3:0] + 4'd1;
        os_sum    = q[7:3] + 5'd1;
        if (os_next)
        begin
            div      = {{FW{1'b0}}, q[NW-1:2*FW]};
            mod_next = {os_sum[4:1], 4'b0000};
        end
        else
        begin
            div      = q[NW-1:FW];
            mod_next = {4'b0000, plain_sum[3:1], 1'b0};
        end
        pre_next = div[PW-1:0];
        ovf_next = |div[DW-1:PW];
        if (err_next)
        begin
            os_next  = 1'b0;
            pre_next = '0;
            mod_next = '0;
            ovf_next = 1'b0;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            os_reg  <= os_next;
            pre_reg <= pre_next;
            mod_reg <= mod_next;
            ovf_reg <= ovf_next;
            err_reg <= err_next;
        end
    end

    assign out_valid          = valid_reg;
    assign oversample         = os_reg;
    assign prescaler          = pre_reg;
    assign modulation         = mod_reg;
    assign prescaler_overflow = ovf_reg;
    assign divide_error       = err_reg;

endmodule

/* tb/sv/ubdc_setting_check.sv */
`timescale 1ns / 100ps
// watches both channels, predicts each baud setting and compares the results
module ubdc_setting_check
(
    input  logic    clk,
    input  logic    rst_n,
    ubdc_req_if     req,
    ubdc_rsp_if     rsp,
    output int      errors,
    output int      in_flight
);

    import ubdc_pkg::*;

    // clock / baud quotient from which the sixteen-times mode is taken
    localparam int unsigned OVERSAMPLE_RATIO = 48;

    typedef struct packed {
        logic                  oversample;
        logic [PRESCALE_W-1:0] prescaler;
        logic [MOD_W-1:0]      modulation;
        logic                  prescaler_overflow;
        logic                  divide_error;
    } baud_setting_t;

    typedef struct packed {
        logic [CLK_W-1:0]  clock_hz;
        logic [BAUD_W-1:0] baud_rate;
        baud_setting_t     setting;
    } pending_setting_t;

    pending_setting_t pending_settings[$];
    pending_setting_t oldest;

    initial
    begin
        errors    = 0;
        in_flight = 0;
    end

    // generator settings for one clock and baud pair
    function automatic baud_setting_t calc_baud_setting(input logic [CLK_W-1:0] clock_hz,
                                                        input logic [BAUD_W-1:0] baud_rate);
        baud_setting_t s;
        logic [63:0]   num;
        logic [63:0]   den;
        logic [63:0]   q;
        logic [63:0]   div;
        s = '0;
        if (baud_rate == '0)
        begin
            s.divide_error = 1'b1;
            return s;
        end
        num = 64'(clock_hz);
        den = 64'(baud_rate);
        s.oversample = ((num / den) >= 64'(OVERSAMPLE_RATIO));
        // quotient in sixteenths, rounding carry out of the modulation bits is lost
        q = (num << 4) / den;
        if (s.oversample)
        begin
            s.modulation = 8'(((q & 64'hF8) + 64'h8) & 64'hF0);
            div          = q >> 8;
        end
        else
        begin
            s.modulation = 8'(((q & 64'hF) + 64'h1) & 64'hE);
            div          = q >> 4;
        end
        s.prescaler          = div[PRESCALE_W-1:0];
        s.prescaler_overflow = (div > 64'hFFFF);
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 100)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // record each request beat, check each result beat against the oldest request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                pending_settings.push_back('{req.clock_hz, req.baud_rate,
                                             calc_baud_setting(req.clock_hz, req.baud_rate)});
            if (rsp.valid && rsp.ready)
            begin
                if (pending_settings.size() == 0)
                    report_mismatch("result beat with no request outstanding");
                else
                begin
                    oldest = pending_settings.pop_front();
                    if (rsp.oversample !== oldest.setting.oversample)
                        report_mismatch($sformatf("clock %0d baud %0d oversample %b want %b",
                            oldest.clock_hz, oldest.baud_rate, rsp.oversample,
                            oldest.setting.oversample));
                    if (rsp.prescaler !== oldest.setting.prescaler)
                        report_mismatch($sformatf("clock %0d baud %0d prescaler %0d want %0d",
                            oldest.clock_hz, oldest.baud_rate, rsp.prescaler,
                            oldest.setting.prescaler));
                    if (rsp.modulation !== oldest.setting.modulation)
                        report_mismatch($sformatf("clock %0d baud %0d modulation %h want %h",
                            oldest.clock_hz, oldest.baud_rate, rsp.modulation,
                            oldest.setting.modulation));
                    if (rsp.prescaler_overflow !== oldest.setting.prescaler_overflow)
                        report_mismatch($sformatf("clock %0d baud %0d overflow %b want %b",
                            oldest.clock_hz, oldest.baud_rate, rsp.prescaler_overflow,
                            oldest.setting.prescaler_overflow));
                    if (rsp.divide_error !== oldest.setting.divide_error)
                        report_mismatch($sformatf("clock %0d baud %0d divide error %b want %b",
                            oldest.clock_hz, oldest.baud_rate, rsp.divide_error,
                            oldest.setting.divide_error));
                end
            end
            in_flight <= pending_settings.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// top of the baud divisor calculator bench: clock, reset, request and result traffic
module testbench;

    import ubdc_pkg::*;

    localparam int unsigned CLOCK_MAX   = 67108863;
    localparam int unsigned BAUD_MAX    = 4194303;
    localparam int          RANDOM_REQS = 1700;
    localparam int          NUM_DIRECT  = 16;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   in_flight;

    // idling controls shared by the request and result processes
    bit          req_idle_en;
    bit          rsp_idle_en;
    int unsigned long_hold;

    int unsigned common_bauds[13] = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600,
                                      115200, 230400, 460800, 921600, 3000000};

    // extremes, mode threshold, modulation carry and overflow edges
    int unsigned direct_clock[NUM_DIRECT] = '{67108863, 1, 67108863, 67108863, 1, 1, 47, 1016,
                                              4800, 4799, 16000000, 1000000, 67108863,
                                              67108863, 33554432, 2097151};
    int unsigned direct_baud[NUM_DIRECT]  = '{1, 4194303, 4194303, 0, 0, 1, 16, 16,
                                              100, 100, 115200, 115200, 64,
                                              63, 2097152, 1};

    ubdc_req_if req_bus ();
    ubdc_rsp_if rsp_bus ();

    uart_baud_divisor_calc i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    ubdc_setting_check i_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .errors    (mismatches),
        .in_flight (in_flight)
    );

    // 20 ns clock
    initial
        clk = 1'b0;
    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #(64'd6_000_000);
        $display("uart_baud_divisor_calc regression: fail");
        $finish;
    end

    // offer one request beat, after a random gap when request idling is on, and hold it until taken
    task automatic send_request(input int unsigned clock_hz, input int unsigned baud_rate);
        int unsigned gap;
        gap = req_idle_en ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.clock_hz  <= CLK_W'(clock_hz);
        req_bus.baud_rate <= BAUD_W'(baud_rate);
        do @(posedge clk); while (!req_bus.ready);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        wait (in_flight == 0);
    endtask

    // pick a request from a mix of value regions
    task automatic draw_request(output int unsigned clock_hz, output int unsigned baud_rate);
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(0, 99);
        clock_hz = $urandom_range(1, CLOCK_MAX);
        if (pick < 25)
            baud_rate = $urandom_range(1, BAUD_MAX);
        else if (pick < 50)
        begin
            // oversampling region
            clock_hz  = $urandom_range(48, CLOCK_MAX);
            baud_rate = $urandom_range(1, clock_hz / 48);
        end
        else if (pick < 60)
            // tiny baud, prescaler overflow likely
            baud_rate = $urandom_range(1, 255);
        else if (pick < 75)
        begin
            // around the mode threshold
            clock_hz  = $urandom_range(64, CLOCK_MAX);
            k         = $urandom_range(44, 52);
            baud_rate = clock_hz / k - 1 + $urandom_range(0, 2);
            if (baud_rate == 0)
                baud_rate = 1;
        end
        else if (pick < 88)
            baud_rate = common_bauds[$urandom_range(0, 12)];
        else if (pick < 93)
            baud_rate = 0;
        else
        begin
            // small operands, varied modulation
            clock_hz  = $urandom_range(1, 1023);
            baud_rate = $urandom_range(1, 1023);
        end
    endtask

    // result side: random stall per beat when result idling is on, one long hold on request
    initial
    begin : result_sink
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            if (long_hold != 0)
            begin
                stall     = long_hold;
                long_hold = 0;
            end
            else
                stall = rsp_idle_en ? $urandom_range(0, 7) : 0;
            @(negedge clk);
            if (stall != 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge clk); while (!rsp_bus.valid);
        end
    end

    // reset, directed requests, random phases, verdict
    initial
    begin : stimulus
        int unsigned clock_v;
        int unsigned baud_v;
        rst_n             = 1'b0;
        req_bus.valid     = 1'b0;
        req_bus.clock_hz  = '0;
        req_bus.baud_rate = '0;
        rsp_bus.ready     = 1'b0;
        req_idle_en       = 1'b1;
        rsp_idle_en       = 1'b1;
        long_hold         = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_DIRECT; i++)
            send_request(direct_clock[i], direct_baud[i]);
        drain_results();

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            // idling pattern changes every 200 beats
            if (i % 200 == 0)
            begin
                case ((i / 200) % 4)
                    0: begin req_idle_en = 1'b1; rsp_idle_en = 1'b1; end
                    1: begin req_idle_en = 1'b0; rsp_idle_en = 1'b0; end
                    2: begin req_idle_en = 1'b1; rsp_idle_en = 1'b0; end
                    default: begin req_idle_en = 1'b0; rsp_idle_en = 1'b1; end
                endcase
            end
            // long result stall while requests keep coming back to back
            if (i == 700)
                long_hold = 150;
            if (i == 1100)
                drain_results();
            draw_request(clock_v, baud_v);
            send_request(clock_v, baud_v);
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("uart_baud_divisor_calc regression: pass");
        else
            $display("uart_baud_divisor_calc regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ubdc_pkg.sv
hw/rtl/ubdc_if.sv
hw/rtl/ubdc_cell.sv
hw/rtl/ubdc_finish.sv
hw/rtl/uart_baud_divisor_calc.sv
tb/sv/ubdc_setting_check.sv
tb/sv/testbench.sv
